@@ hw/rtl/fev1dec_pkg.sv @@
`default_nettype none

package fev1dec_pkg;

    // datagram framing
    localparam int LENGTH_BITS = 16;
    localparam int BLEFT_W     = 17;
    localparam int HDR_LEN     = 16;
    localparam int REC_LEN     = 48;
    localparam int POS_W       = 6;
    localparam int NEED_W      = 22;

    // reset value of the record limit
    localparam logic [7:0] MAX_REC_RESET = 8'd24;

    // boot time arithmetic: nsecs / 1000000 as (nsecs >> 6) / 15625 by reciprocal
    localparam int          MS_PER_S    = 1000;
    localparam int          SECS_MS_W   = 42;
    localparam int          NS_SHIFT    = 6;
    localparam int          NS_PROD_W   = 53;
    localparam int          NS_RECIP_SH = 40;
    localparam int          NS_Q_W      = 13;
    localparam logic [26:0] NS_RECIP    = 27'd70368745;

    // job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // result status codes
    localparam logic [1:0] ST_FLOW      = 2'd0;
    localparam logic [1:0] ST_BAD_COUNT = 2'd1;
    localparam logic [1:0] ST_SHORT     = 2'd2;

    // protocol number of icmp
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        end_of_datagram;
        logic [15:0] datagram_length;
        logic [63:0] receive_time_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [31:0] next_hop_address;
        logic [31:0] interfaces;
        logic [31:0] packet_total;
        logic [31:0] octet_total;
        logic [31:0] port_pair;
        logic [23:0] proto_tos_flags;
        logic [63:0] start_ms;
        logic [63:0] end_ms;
        logic [63:0] received_ms;
    } t_out_item;

    // one parsed record or error, as handed from front to back
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] nh_addr;
        logic [31:0] ifaces;
        logic [31:0] pkts;
        logic [31:0] octets;
        logic [31:0] first;
        logic [31:0] last;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [7:0]  tos;
        logic [7:0]  flag_bits;
        logic [63:0] boot_ms;
        logic [31:0] uptime_ms;
        logic [63:0] arrival_ms;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

@@ hw/rtl/fev1dec_front.sv @@
`default_nettype none

module fev1dec_front import fev1dec_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_stall,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_job     o_push_job
);

    logic [7:0]         r_win [REC_LEN-1];
    logic [7:0]         w [REC_LEN];
    logic [7:0]         r_max_records;
    logic [POS_W-1:0]   r_pos, n_pos, e_pos;
    logic               r_in_header, n_in_header, e_in_header;
    logic [7:0]         r_records_left, n_records_left, e_records_left;
    logic [BLEFT_W-1:0] r_bytes_left, n_bytes_left, e_bytes_left;
    logic               r_dropping, n_dropping, e_dropping;
    logic               r_sod, n_sod;
    logic [63:0]        r_arrival, n_arrival;
    logic               accept;
    logic [15:0]        count;
    logic [NEED_W-1:0]  need;
    logic               bad_count, too_short, hdr_done, rec_done, hdr_ok;

    // boot time pipeline
    logic [31:0]          r_up, r_secs, r_nsecs;
    logic                 r_p1, r_p2;
    logic [SECS_MS_W-1:0] r_secs_ms;
    logic [NS_Q_W-1:0]    r_ns_q;
    logic [NS_PROD_W-1:0] ns_prod;
    logic [63:0]          r_boot;

    assign accept      = i_in_valid && !i_q_stat.full;
    assign o_in_stall  = i_q_stat.full;
    assign o_cfg_ready = 1'b1;

    // byte window: w[0] oldest, w[last] the byte now offered
    always_comb begin
        for (int i = 0; i < REC_LEN - 1; i++) begin
            w[i] = r_win[i];
        end
        w[REC_LEN-1] = i_in_item.data_byte;
    end

    // state as seen by this byte, with the start of a datagram applied
    always_comb begin
        e_pos          = r_sod ? '0 : r_pos;
        e_in_header    = r_sod ? 1'b1 : r_in_header;
        e_records_left = r_sod ? '0 : r_records_left;
        e_dropping     = r_sod ? 1'b0 : r_dropping;
        e_bytes_left   = r_sod ? BLEFT_W'(i_in_item.datagram_length[LENGTH_BITS-1:0])
                               : r_bytes_left;
        n_arrival      = r_sod ? i_in_item.receive_time_ms : r_arrival;
    end

    // header checks, header bytes sit in the last sixteen window slots
    assign count     = {w[34], w[35]};
    assign need      = NEED_W'({count, 5'b0}) + NEED_W'({count, 4'b0}) + NEED_W'(HDR_LEN);
    assign bad_count = (count == 16'd0) || (count > {8'd0, r_max_records});
    assign too_short = NEED_W'(e_bytes_left) < need;
    assign hdr_done  = accept && !e_dropping && e_in_header
                    && (e_pos == POS_W'(HDR_LEN - 1));
    assign rec_done  = accept && !e_dropping && !e_in_header
                    && (e_pos == POS_W'(REC_LEN - 1));
    assign hdr_ok    = hdr_done && !bad_count && !too_short;

    // parse state next values
    always_comb begin
        n_pos          = r_pos;
        n_in_header    = r_in_header;
        n_records_left = r_records_left;
        n_bytes_left   = r_bytes_left;
        n_dropping     = r_dropping;
        n_sod          = r_sod;
        if (accept) begin
            n_pos          = e_pos;
            n_in_header    = e_in_header;
            n_records_left = e_records_left;
            n_bytes_left   = e_bytes_left;
            n_dropping     = e_dropping;
            n_sod          = i_in_item.end_of_datagram;
            if (!e_dropping) begin
                if (e_in_header) begin
                    if (e_pos == POS_W'(HDR_LEN - 1)) begin
                        n_pos = '0;
                        if (bad_count || too_short) begin
                            n_dropping = 1'b1;
                        end else begin
                            n_records_left = count[7:0];
                            n_bytes_left   = e_bytes_left - need[BLEFT_W-1:0];
                            n_in_header    = 1'b0;
                        end
                    end else begin
                        n_pos = e_pos + 1'b1;
                    end
                end else begin
                    if (e_pos == POS_W'(REC_LEN - 1)) begin
                        n_pos          = '0;
                        n_records_left = e_records_left - 8'd1;
                        if (n_records_left == 8'd0) begin
                            if (e_bytes_left < BLEFT_W'(HDR_LEN)) begin
                                n_dropping = 1'b1;
                            end else begin
                                n_in_header = 1'b1;
                            end
                        end
                    end else begin
                        n_pos = e_pos + 1'b1;
                    end
                end
            end
        end
    end

    // job to the queue: a finished record or a rejected header
    always_comb begin
        o_push     = rec_done || (hdr_done && (bad_count || too_short));
        o_push_job = '0;
        if (rec_done) begin
            o_push_job.status     = ST_FLOW;
            o_push_job.src_addr   = {w[0], w[1], w[2], w[3]};
            o_push_job.dst_addr   = {w[4], w[5], w[6], w[7]};
            o_push_job.nh_addr    = {w[8], w[9], w[10], w[11]};
            o_push_job.ifaces     = {w[12], w[13], w[14], w[15]};
            o_push_job.pkts       = {w[16], w[17], w[18], w[19]};
            o_push_job.octets     = {w[20], w[21], w[22], w[23]};
            o_push_job.first      = {w[24], w[25], w[26], w[27]};
            o_push_job.last       = {w[28], w[29], w[30], w[31]};
            o_push_job.sport      = {w[32], w[33]};
            o_push_job.dport      = {w[34], w[35]};
            o_push_job.proto      = w[38];
            o_push_job.tos        = w[39];
            o_push_job.flag_bits  = w[40];
            o_push_job.boot_ms    = r_boot;
            o_push_job.uptime_ms  = r_up;
            o_push_job.arrival_ms = n_arrival;
        end else begin
            o_push_job.status = bad_count ? ST_BAD_COUNT : ST_SHORT;
        end
    end

    // window shift
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < REC_LEN - 2; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[REC_LEN-2] <= i_in_item.data_byte;
        end
    end

    // control state and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_records  <= MAX_REC_RESET;
            r_pos          <= '0;
            r_in_header    <= 1'b1;
            r_records_left <= '0;
            r_bytes_left   <= '0;
            r_dropping     <= 1'b0;
            r_sod          <= 1'b1;
            r_arrival      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max_records <= i_cfg_data;
            end
            r_pos          <= n_pos;
            r_in_header    <= n_in_header;
            r_records_left <= n_records_left;
            r_bytes_left   <= n_bytes_left;
            r_dropping     <= n_dropping;
            r_sod          <= n_sod;
            if (accept) begin
                r_arrival <= n_arrival;
            end
        end
    end

    // boot time: capture, multiply stage, then sum stage
    assign ns_prod = NS_PROD_W'(r_nsecs[31:NS_SHIFT]) * NS_PROD_W'(NS_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1   <= 1'b0;
            r_p2   <= 1'b0;
            r_up   <= '0;
            r_boot <= '0;
        end else begin
            r_p1 <= hdr_ok;
            r_p2 <= r_p1;
            if (hdr_ok) begin
                r_up <= {w[36], w[37], w[38], w[39]};
            end
            if (r_p2) begin
                r_boot <= 64'(r_secs_ms) + 64'(r_ns_q) - 64'(r_up);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_ok) begin
            r_secs  <= {w[40], w[41], w[42], w[43]};
            r_nsecs <= {w[44], w[45], w[46], w[47]};
        end
        if (r_p1) begin
            r_secs_ms <= SECS_MS_W'(r_secs) * SECS_MS_W'(MS_PER_S);
            r_ns_q    <= ns_prod[NS_RECIP_SH +: NS_Q_W];
        end
    end

    // a rejected header stops parsing for the rest of the datagram
    a_reject_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hdr_done && (bad_count || too_short)) |=> r_dropping)
        else $error("rejected header did not start dropping");

    // header offsets never pass the header length
    a_hdr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_header |-> (r_pos < POS_W'(HDR_LEN)))
        else $error("header byte position out of range");

endmodule

`default_nettype wire

@@ hw/rtl/fev1dec_queue.sv @@
`default_nettype none

module fev1dec_queue import fev1dec_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_push_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_q_stat
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, r_rptr;
    logic [Q_CW-1:0] r_count;

    assign o_head         = r_mem[r_rptr];
    assign o_q_stat.empty = (r_count == '0);
    assign o_q_stat.full  = (r_count == Q_CW'(Q_DEPTH));

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_q_stat.full))
        else $error("item pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_q_stat.empty))
        else $error("item popped from an empty queue");

endmodule

`default_nettype wire

@@ hw/rtl/fev1dec_back.sv @@
`default_nettype none

module fev1dec_back import fev1dec_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_stat   i_q_stat,
    input  t_job      i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_valid;
    t_out_item r_item, n_item;
    logic      wrap_first, wrap_up;
    logic      icmp_fix;
    logic [31:0] start_hi, end_hi;

    assign o_pop       = !i_q_stat.empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    // uptime wrap: each wrap takes 2^32 off the upper word
    assign wrap_first = i_head.first > i_head.last;
    assign wrap_up    = i_head.last > i_head.uptime_ms;
    assign start_hi   = 32'd0 - 32'(wrap_first) - 32'(wrap_up);
    assign end_hi     = 32'd0 - 32'(wrap_up);
    assign icmp_fix   = (i_head.proto == PROTO_ICMP) && (i_head.sport != 16'd0);

    // decode the head job into a result
    always_comb begin
        n_item        = '0;
        n_item.status = i_head.status;
        if (i_head.status == ST_FLOW) begin
            n_item.source_address      = i_head.src_addr;
            n_item.destination_address = i_head.dst_addr;
            n_item.next_hop_address    = i_head.nh_addr;
            n_item.interfaces          = i_head.ifaces;
            n_item.packet_total        = i_head.pkts;
            n_item.octet_total         = i_head.octets;
            n_item.port_pair           = icmp_fix
                ? {16'd0, i_head.sport[7:0], i_head.sport[15:8]}
                : {i_head.sport, i_head.dport};
            n_item.proto_tos_flags     = {i_head.proto, i_head.tos, i_head.flag_bits};
            n_item.start_ms            = i_head.boot_ms + {start_hi, i_head.first};
            n_item.end_ms              = i_head.boot_ms + {end_hi, i_head.last};
            n_item.received_ms         = i_head.arrival_ms;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= n_item;
        end
    end

    // error results carry nothing but their status
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.status != ST_FLOW) |->
            (r_item.source_address == 32'd0 && r_item.start_ms == 64'd0
             && r_item.received_ms == 64'd0))
        else $error("error result with nonzero fields");

endmodule

`default_nettype wire

@@ hw/rtl/flow_export_v1_decoder_core.sv @@
`default_nettype none

// channel   valid        flow ctl      payload
// -------   -----------  ------------  --------------------------
// in        i_in_valid   o_in_stall    i_in_item   (t_in_item)
// out       o_out_valid  i_out_stall   o_out_item  (t_out_item)
// cfg       i_cfg_valid  o_cfg_ready   i_cfg_data  (max_records)
//
// one byte per cycle unless stalled; header checks run on the byte completing the header
// a finished result is pushed to the job queue, then registered at the output
// boot time passes through its multiply and sum stages, well before the next record
// o_in_stall rises only when the four-item job queue is full; o_out_valid holds on stall
// synchronous reset clears parse state and sets max_records to 24; no clearing pass

module flow_export_v1_decoder_core import fev1dec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_item,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_q_stat q_stat;
    logic    push, pop;
    t_job    push_job, head;

    // parser: accepts bytes and builds jobs
    fev1dec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_push_job (push_job)
    );

    // job queue
    fev1dec_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_job(push_job),
        .i_pop     (pop),
        .o_head    (head),
        .o_q_stat  (q_stat)
    );

    // record decode and output register
    fev1dec_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (q_stat),
        .i_head     (head),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

@@ test/flow_export_v1_decoder_core_tb.sv @@
module flow_export_v1_decoder_core_tb import fev1dec_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] UPTIME_WRAP    = 64'h1_0000_0000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 2000;

    typedef enum int {
        REC_RANDOM,
        REC_ICMP,
        REC_ICMP_NO_PORT,
        REC_ONES,
        REC_ZEROS
    } t_rec_kind;

    // decoder prediction and the queue of flow results still to come
    class t_decoder_scoreboard;
        bit [7:0]  max_rec;
        bit [5:0]  pos;
        bit        in_hdr;
        bit [7:0]  recs_left;
        bit [16:0] bytes_left;
        bit        dropping;
        bit        sod;
        bit [31:0] uptime;
        bit [63:0] boot;
        bit [63:0] arrival;
        bit [7:0]  rec [REC_LEN];
        t_out_item flow_q[$];
        int unsigned n_expected;
        int unsigned n_errors;

        function new();
            max_rec = MAX_REC_RESET;
            in_hdr  = 1'b1;
            sod     = 1'b1;
        endfunction

        function bit [15:0] be16(int i);
            return {rec[i], rec[i + 1]};
        endfunction

        function bit [31:0] be32(int i);
            return {rec[i], rec[i + 1], rec[i + 2], rec[i + 3]};
        endfunction

        // count and length checks on the byte that completes a header
        function bit check_header(output t_out_item r);
            bit [15:0]   cnt;
            int unsigned need;
            bit [63:0]   secs;
            bit [63:0]   nsecs;
            r    = '0;
            cnt  = be16(2);
            need = HDR_LEN + cnt * REC_LEN;
            if (cnt == 0 || cnt > max_rec) begin
                r.status = ST_BAD_COUNT;
                dropping = 1'b1;
                return 1'b1;
            end
            if (bytes_left < need) begin
                r.status = ST_SHORT;
                dropping = 1'b1;
                return 1'b1;
            end
            uptime     = be32(4);
            secs       = be32(8);
            nsecs      = be32(12);
            boot       = secs * 64'd1000 + nsecs / 64'd1000000 - {32'd0, uptime};
            recs_left  = cnt[7:0];
            bytes_left = bytes_left - need[16:0];
            in_hdr     = 1'b0;
            return 1'b0;
        endfunction

        // field decode, uptime wrap and icmp port fix
        function void decode_record(output t_out_item r);
            bit [63:0] first_ms;
            bit [63:0] last_ms;
            bit [63:0] st;
            bit [63:0] en;
            bit [15:0] sp;
            bit [15:0] dp;
            bit [7:0]  proto;
            first_ms = be32(24);
            last_ms  = be32(28);
            sp       = be16(32);
            dp       = be16(34);
            proto    = rec[38];
            if (first_ms > last_ms)
                st = boot - UPTIME_WRAP + first_ms;
            else
                st = boot + first_ms;
            en = boot + last_ms;
            if (last_ms > {32'd0, uptime}) begin
                st = st - UPTIME_WRAP;
                en = en - UPTIME_WRAP;
            end
            if (proto == PROTO_ICMP && sp != 0) begin
                dp = {sp[7:0], sp[15:8]};
                sp = '0;
            end
            r                     = '0;
            r.status              = ST_FLOW;
            r.source_address      = be32(0);
            r.destination_address = be32(4);
            r.next_hop_address    = be32(8);
            r.interfaces          = be32(12);
            r.packet_total        = be32(16);
            r.octet_total         = be32(20);
            r.port_pair           = {sp, dp};
            r.proto_tos_flags     = {proto, rec[39], rec[40]};
            r.start_ms            = st;
            r.end_ms              = en;
            r.received_ms         = arrival;
        endfunction

        // advance the parser by one accepted item
        function void note_byte(t_in_item it);
            t_out_item   r;
            bit          hit;
            int unsigned p;
            hit = 1'b0;
            if (sod) begin
                bytes_left = {1'b0, it.datagram_length};
                arrival    = it.receive_time_ms;
                pos        = '0;
                in_hdr     = 1'b1;
                recs_left  = '0;
                dropping   = 1'b0;
                sod        = 1'b0;
            end
            if (!dropping) begin
                p = pos;
                if (p >= REC_LEN)
                    p = 0;
                rec[p] = it.data_byte;
                if (in_hdr) begin
                    if (p == HDR_LEN - 1) begin
                        pos = '0;
                        hit = check_header(r);
                    end else begin
                        pos = 6'(p + 1);
                    end
                end else begin
                    if (p == REC_LEN - 1) begin
                        pos = '0;
                        decode_record(r);
                        hit       = 1'b1;
                        recs_left = recs_left - 8'd1;
                        if (recs_left == 0) begin
                            if (bytes_left < HDR_LEN)
                                dropping = 1'b1;
                            else
                                in_hdr = 1'b1;
                        end
                    end else begin
                        pos = 6'(p + 1);
                    end
                end
            end
            if (it.end_of_datagram)
                sod = 1'b1;
            if (hit) begin
                flow_q.push_back(r);
                n_expected++;
            end
        endfunction

        function void cmp(string fld, logic [63:0] e, logic [63:0] a);
            if (a !== e) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, fld, e, a);
                n_errors++;
            end
        endfunction

        // compare one output item with the oldest prediction
        function void check_result(t_out_item a);
            t_out_item e;
            if (flow_q.size() == 0) begin
                $display("%0t: unexpected item, expected none actual status %h",
                         $time, a.status);
                n_errors++;
                return;
            end
            e = flow_q.pop_front();
            cmp("status", 64'(e.status), 64'(a.status));
            cmp("source_address", 64'(e.source_address), 64'(a.source_address));
            cmp("destination_address", 64'(e.destination_address),
                64'(a.destination_address));
            cmp("next_hop_address", 64'(e.next_hop_address), 64'(a.next_hop_address));
            cmp("interfaces", 64'(e.interfaces), 64'(a.interfaces));
            cmp("packet_total", 64'(e.packet_total), 64'(a.packet_total));
            cmp("octet_total", 64'(e.octet_total), 64'(a.octet_total));
            cmp("port_pair", 64'(e.port_pair), 64'(a.port_pair));
            cmp("proto_tos_flags", 64'(e.proto_tos_flags), 64'(a.proto_tos_flags));
            cmp("start_ms", e.start_ms, a.start_ms);
            cmp("end_ms", e.end_ms, a.end_ms);
            cmp("received_ms", e.received_ms, a.received_ms);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    t_in_item   i_in_item;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    t_decoder_scoreboard sb;
    bit [7:0]            dg [$];
    int unsigned         send_idle = 0;
    int unsigned         recv_idle = 0;
    int unsigned         bytes_sent = 0;

    flow_export_v1_decoder_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // datagram building
    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void put16(bit [15:0] v);
        dg.push_back(v[15:8]);
        dg.push_back(v[7:0]);
    endfunction

    function automatic void put32(bit [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endfunction

    function automatic void put_header(bit [15:0] count, bit [31:0] up);
        put16(16'($urandom));
        put16(count);
        put32(up);
        put32($urandom);
        put32($urandom);
    endfunction

    function automatic void put_record(t_rec_kind kind);
        int base;
        base = dg.size();
        repeat (REC_LEN) begin
            if (kind == REC_ONES)
                dg.push_back(8'hff);
            else if (kind == REC_ZEROS)
                dg.push_back(8'h00);
            else
                dg.push_back(8'($urandom));
        end
        if (kind == REC_ICMP || kind == REC_ICMP_NO_PORT)
            dg[base + 38] = PROTO_ICMP;
        if (kind == REC_ICMP)
            dg[base + 32] = 8'($urandom_range(1, 255));
        if (kind == REC_ICMP_NO_PORT) begin
            dg[base + 32] = 8'h00;
            dg[base + 33] = 8'h00;
        end
    endfunction

    // overwrite first and last switched times of the newest record
    function automatic void set_times(bit [31:0] first_ms, bit [31:0] last_ms);
        int base;
        base = dg.size() - REC_LEN;
        for (int i = 0; i < 4; i++) begin
            dg[base + 24 + i] = first_ms[31 - 8 * i -: 8];
            dg[base + 28 + i] = last_ms[31 - 8 * i -: 8];
        end
    endfunction

    function automatic void put_noise(int unsigned n);
        repeat (n) dg.push_back(8'($urandom));
    endfunction

    function automatic t_rec_kind pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30)
            return REC_ICMP;
        else if (r < 40)
            return REC_ICMP_NO_PORT;
        return REC_RANDOM;
    endfunction

    // one input item, with random gaps before it
    task automatic send_byte(t_in_item it);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(it);
        bytes_sent++;
    endtask

    // length and arrival time matter only on the first item
    task automatic send_datagram(int unsigned len, bit [63:0] rx);
        t_in_item it;
        for (int i = 0; i < dg.size(); i++) begin
            it.data_byte       = dg[i];
            it.end_of_datagram = (i == dg.size() - 1);
            it.datagram_length = (i == 0) ? len[15:0] : 16'($urandom);
            it.receive_time_ms = (i == 0) ? rx : rand64();
            send_byte(it);
        end
        dg.delete();
    endtask

    // wait for all flow results, then let the pipeline settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.flow_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_records(bit [7:0] v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.max_rec = v;
    endtask

    task automatic run_directed();
        // icmp port swap, first after last, last within uptime, result on end
        put_header(1, 32'd1000);
        put_record(REC_ICMP);
        set_times(32'd2000, 32'd500);
        send_datagram(64, 64'd0);
        // last beyond uptime, icmp without port, extra items past the length
        put_header(2, 32'd1000);
        put_record(REC_RANDOM);
        set_times(32'd100, 32'd5000);
        put_record(REC_ICMP_NO_PORT);
        set_times(32'd10, 32'd20);
        put_noise(5);
        send_datagram(112, '1);
        // two blocks, all-ones and all-zeros records, trailing fragment
        put_header(1, $urandom);
        put_record(REC_ONES);
        put_header(1, $urandom);
        put_record(REC_ZEROS);
        put_noise(10);
        send_datagram(138, rand64());
        // bad counts
        put_header(0, $urandom);
        put_noise(20);
        send_datagram(36, rand64());
        put_header(25, $urandom);
        put_noise(10);
        send_datagram(64, rand64());
        put_header(16'hffff, $urandom);
        put_noise(3);
        send_datagram(16'hffff, rand64());
        // short datagram, and a length below one header
        put_header(1, $urandom);
        put_record(REC_RANDOM);
        send_datagram(63, rand64());
        put_header(1, $urandom);
        put_record(REC_RANDOM);
        send_datagram(5, rand64());
        // early end inside a header, inside a record, inside a second header
        put_header(1, $urandom);
        while (dg.size() > 8) dg.pop_back();
        send_datagram(64, rand64());
        put_header(1, $urandom);
        put_noise(20);
        send_datagram(64, rand64());
        put_header(1, $urandom);
        put_record(REC_RANDOM);
        put_noise(6);
        send_datagram(200, rand64());
        // single item datagram with zero length
        put_noise(1);
        send_datagram(0, rand64());
        // smallest limit
        write_max_records(8'd1);
        put_header(1, $urandom);
        put_record(REC_ICMP);
        send_datagram(64, rand64());
        put_header(2, $urandom);
        send_datagram(200, rand64());
        // largest limit: 255 passes the count check, 256 does not
        write_max_records(8'd255);
        put_header(255, $urandom);
        send_datagram(16, rand64());
        put_header(256, $urandom);
        send_datagram(16, rand64());
        put_header(255, $urandom);
        put_noise(4);
        send_datagram(16'hffff, rand64());
    endtask

    // mostly well formed datagrams with random content, some broken or noise
    task automatic random_datagram();
        int unsigned pick;
        int unsigned cnt;
        int unsigned cap;
        int unsigned len;
        int unsigned cut;
        bit [63:0]   rx;
        rx   = rand64();
        pick = $urandom_range(99);
        cap  = (sb.max_rec < 3) ? sb.max_rec : 3;
        if (pick < 65) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(9) == 0)
                    cnt = $urandom_range(1, (sb.max_rec < 8) ? sb.max_rec : 8);
                else
                    cnt = $urandom_range(1, cap);
                put_header(16'(cnt), $urandom);
                repeat (cnt) put_record(pick_kind());
            end
            if ($urandom_range(3) == 0)
                put_noise($urandom_range(1, 15));
            len = dg.size();
            case ($urandom_range(9))
                0: put_noise($urandom_range(1, 20));
                1: len = len + $urandom_range(1, 40);
                default: ;
            endcase
        end else if (pick < 75) begin
            cnt = ($urandom_range(2) == 0) ? 0 : $urandom_range(sb.max_rec + 1, 65535);
            put_header(16'(cnt), $urandom);
            put_noise($urandom_range(0, 60));
            len = $urandom_range(0, 65535);
        end else if (pick < 85) begin
            cnt = $urandom_range(1, cap);
            put_header(16'(cnt), $urandom);
            repeat (cnt) put_record(pick_kind());
            len = $urandom_range(0, HDR_LEN + cnt * REC_LEN - 1);
        end else if (pick < 93) begin
            cnt = $urandom_range(1, cap);
            put_header(16'(cnt), $urandom);
            repeat (cnt) put_record(pick_kind());
            len = dg.size();
            cut = $urandom_range(1, dg.size() - 1);
            while (dg.size() > cut) dg.pop_back();
        end else begin
            put_noise($urandom_range(1, 80));
            len = $urandom_range(0, 65535);
        end
        send_datagram(len, rx);
    endtask

    task automatic run_phase(int unsigned n_bytes, int unsigned n_results);
        int unsigned b0;
        int unsigned r0;
        b0 = bytes_sent;
        r0 = sb.n_expected;
        while (bytes_sent - b0 < n_bytes || sb.n_expected - r0 < n_results)
            random_datagram();
    endtask

    // receiver stall
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // output monitor
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_result(o_out_item);
        end
    end

    // watchdog on cycles with no handshake at all
    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
                break;
        end
        $display("TEST FAILED");
        $finish;
    end

    // main sequence
    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        write_max_records(8'($urandom_range(2, 255)));
        send_idle = 7;
        recv_idle = 50;
        run_phase(120, 2);

        write_max_records(MAX_REC_RESET);
        send_idle = 50;
        recv_idle = 7;
        run_phase(120, 2);

        write_max_records(8'($urandom_range(1, 255)));
        send_idle = 0;
        recv_idle = 0;
        run_phase(120, 2);

        drain_results();
        if (sb.n_errors == 0 && sb.flow_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/fev1dec_pkg.sv
hw/rtl/fev1dec_front.sv
hw/rtl/fev1dec_queue.sv
hw/rtl/fev1dec_back.sv
hw/rtl/flow_export_v1_decoder_core.sv
test/flow_export_v1_decoder_core_tb.sv
